// ===== hdl/fjdr_pkg.sv =====
// ----------------------------------------------------------------------------
// fjdr_pkg
// Types and constants shared by the feeder jam detect and reverse block.
// ----------------------------------------------------------------------------
package fjdr_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // register indexes of the control port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POSITION_TOLERANCE = 3'd0,
      CSR_SPEED_FLOOR        = 3'd1,
      CSR_LIMIT_SINGLE       = 3'd2,
      CSR_LIMIT_TRIPLE       = 3'd3,
      CSR_LIMIT_FULL_AUTO    = 3'd4,
      CSR_LIMIT_HOST_CTRL    = 3'd5,
      CSR_REVERSE_TICKS      = 3'd6,
      CSR_REVERSE_SPEED      = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_SINGLE    = 2'd0,
      MODE_TRIPLE    = 2'd1,
      MODE_FULL_AUTO = 2'd2,
      MODE_HOST_CTRL = 2'd3
   } mode_type;

   typedef struct packed {
      logic [15:0]        position_tolerance;
      logic [14:0]        speed_floor;
      logic [7:0]         limit_single;
      logic [7:0]         limit_triple;
      logic [7:0]         limit_full_auto;
      logic [7:0]         limit_host_ctrl;
      logic [7:0]         reverse_ticks;
      logic signed [15:0] reverse_speed;
   } cfg_type;

   localparam logic [15:0]        RST_POSITION_TOLERANCE = 16'd2000;
   localparam logic [14:0]        RST_SPEED_FLOOR        = 15'd500;
   localparam logic [7:0]         RST_LIMIT_SINGLE       = 8'd100;
   localparam logic [7:0]         RST_LIMIT_TRIPLE       = 8'd250;
   localparam logic [7:0]         RST_LIMIT_FULL_AUTO    = 8'd50;
   localparam logic [7:0]         RST_LIMIT_HOST_CTRL    = 8'd101;
   localparam logic [7:0]         RST_REVERSE_TICKS      = 8'd20;
   localparam logic signed [15:0] RST_REVERSE_SPEED      = -16'sd2000;

endpackage

// ===== hdl/fjdr_csr.sv =====
// ----------------------------------------------------------------------------
// fjdr_csr
// Control register file: write-only settings for jam detection and reverse.
// ----------------------------------------------------------------------------
module fjdr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [fjdr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fjdr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output fjdr_pkg::cfg_type                cfg
);
   import fjdr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_POSITION_TOLERANCE: cfg_in.position_tolerance = csr_wdata;
            CSR_SPEED_FLOOR:        cfg_in.speed_floor        = csr_wdata[14:0];
            CSR_LIMIT_SINGLE:       cfg_in.limit_single       = csr_wdata[7:0];
            CSR_LIMIT_TRIPLE:       cfg_in.limit_triple       = csr_wdata[7:0];
            CSR_LIMIT_FULL_AUTO:    cfg_in.limit_full_auto    = csr_wdata[7:0];
            CSR_LIMIT_HOST_CTRL:    cfg_in.limit_host_ctrl    = csr_wdata[7:0];
            CSR_REVERSE_TICKS:      cfg_in.reverse_ticks      = csr_wdata[7:0];
            CSR_REVERSE_SPEED:      cfg_in.reverse_speed      = $signed(csr_wdata);
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.position_tolerance <= RST_POSITION_TOLERANCE;
         cfg_ff.speed_floor        <= RST_SPEED_FLOOR;
         cfg_ff.limit_single       <= RST_LIMIT_SINGLE;
         cfg_ff.limit_triple       <= RST_LIMIT_TRIPLE;
         cfg_ff.limit_full_auto    <= RST_LIMIT_FULL_AUTO;
         cfg_ff.limit_host_ctrl    <= RST_LIMIT_HOST_CTRL;
         cfg_ff.reverse_ticks      <= RST_REVERSE_TICKS;
         cfg_ff.reverse_speed      <= RST_REVERSE_SPEED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/feeder_jam_detect_reverse_core.sv =====
// ----------------------------------------------------------------------------
// feeder_jam_detect_reverse_core
// Feeder jam detection with a timed reverse override of the speed target.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one control tick per transfer (valid/ready). rsp_* returns
//   exactly one result per tick, in order (valid/ready). csr_* is a write-only
//   register port; the user must write it only while the block is idle, which
//   the block leaves unchecked. The position error is formed into the input
//   register; the stall compare, counter update and reverse sequencing then
//   run into the result register once the result stage is free. One tick is
//   accepted every cycle while the result stage is free or the input stage
//   is empty; the stall counters and reverse counter are updated as a tick
//   moves into the result register, so the next tick sees them at once.
//   Reset clears both stages, all stall counters, the reverse state and
//   loads the default register values.
//   When rsp_ready is low the result holds, the input stage still fills once,
//   and req_ready then drops until the result is taken.
// ----------------------------------------------------------------------------
module feeder_jam_detect_reverse_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_fire_mode,
   input  logic                             req_firing_idle,
   input  logic signed [31:0]               req_encoder_position,
   input  logic signed [31:0]               req_position_target,
   input  logic signed [15:0]               req_measured_speed,
   input  logic signed [15:0]               req_speed_target_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [15:0]               rsp_speed_target_out,
   output logic                             rsp_reversing,
   output logic                             rsp_jam_detected,
   input  logic                             csr_we,
   input  logic [fjdr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fjdr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fjdr_pkg::*;

   cfg_type cfg;

   // input stage
   logic               s1_valid_ff, s1_valid_in;
   mode_type           s1_mode_ff;
   logic               s1_idle_ff;
   logic signed [32:0] s1_err_ff;
   logic signed [15:0] s1_speed_ff;
   logic signed [15:0] s1_target_ff;

   // jam state
   logic [7:0] cnt_ff [4];
   logic [7:0] cnt_in [4];
   logic       jam_active_ff, jam_active_in;
   logic [7:0] rev_count_ff, rev_count_in;

   // result stage
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_speed_ff;
   logic               rsp_rev_ff;
   logic               rsp_jam_ff;

   logic               out_free;
   logic               req_xfer;
   logic               s1_fire;
   logic signed [32:0] err_in;
   logic signed [32:0] tol_pos;
   logic signed [32:0] tol_neg;
   logic               pos_stall;
   logic signed [16:0] spd_wide;
   logic [16:0]        spd_mag;
   logic               spd_stall;
   logic               stall;
   logic [7:0]         prev_cnt;
   logic [7:0]         new_cnt;
   logic [7:0]         limit;
   logic               jam;
   logic               rev;
   logic [7:0]         rev_inc;

   fjdr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_xfer  = req_valid && req_ready;
   assign s1_fire   = s1_valid_ff && out_free;

   // exact 33-bit position error
   assign err_in = {req_encoder_position[31], req_encoder_position}
                 - {req_position_target[31], req_position_target};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // stall detection
   assign tol_pos   = $signed({17'd0, cfg.position_tolerance});
   assign tol_neg   = -tol_pos;
   assign pos_stall = (s1_err_ff > tol_pos) || (s1_err_ff < tol_neg);

   assign spd_wide  = {s1_speed_ff[15], s1_speed_ff};
   assign spd_mag   = spd_wide[16] ? 17'(-spd_wide) : 17'(spd_wide);
   assign spd_stall = spd_mag < {2'd0, cfg.speed_floor};

   assign stall    = (s1_mode_ff == MODE_FULL_AUTO) ? spd_stall : pos_stall;
   assign prev_cnt = s1_idle_ff ? 8'd0 : cnt_ff[s1_mode_ff];
   assign new_cnt  = stall ? 8'(prev_cnt + 8'd1) : 8'd0;

   always_comb begin
      case (s1_mode_ff)
         MODE_SINGLE:    limit = cfg.limit_single;
         MODE_TRIPLE:    limit = cfg.limit_triple;
         MODE_FULL_AUTO: limit = cfg.limit_full_auto;
         MODE_HOST_CTRL: limit = cfg.limit_host_ctrl;
         default:        limit = cfg.limit_host_ctrl;
      endcase
   end

   assign jam     = new_cnt >= limit;
   assign rev_inc = 8'(rev_count_ff + 8'd1);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cnt_in[i] = (2'(i) == s1_mode_ff && !jam) ? new_cnt : 8'd0;
      end
   end

   // reverse sequencing; a jam during a reversal does not restart it
   always_comb begin
      rev           = 1'b0;
      jam_active_in = jam_active_ff;
      rev_count_in  = rev_count_ff;
      if (jam_active_ff || jam) begin
         if (rev_inc >= cfg.reverse_ticks) begin
            jam_active_in = 1'b0;
            rev_count_in  = 8'd0;
         end else begin
            rev           = 1'b1;
            jam_active_in = 1'b1;
            rev_count_in  = rev_inc;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         jam_active_ff <= 1'b0;
         rev_count_ff  <= 8'd0;
         for (int i = 0; i < 4; i++) begin
            cnt_ff[i] <= 8'd0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            jam_active_ff <= jam_active_in;
            rev_count_ff  <= rev_count_in;
            for (int i = 0; i < 4; i++) begin
               cnt_ff[i] <= cnt_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_mode_ff   <= mode_type'(req_fire_mode);
         s1_idle_ff   <= req_firing_idle;
         s1_err_ff    <= err_in;
         s1_speed_ff  <= req_measured_speed;
         s1_target_ff <= req_speed_target_in;
      end
      if (s1_fire) begin
         rsp_speed_ff <= rev ? cfg.reverse_speed : s1_target_ff;
         rsp_rev_ff   <= rev;
         rsp_jam_ff   <= jam;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_speed_target_out = rsp_speed_ff;
   assign rsp_reversing        = rsp_rev_ff;
   assign rsp_jam_detected     = rsp_jam_ff;

endmodule

// ===== hdl/fjdr_checker.sv =====
// ----------------------------------------------------------------------------
// fjdr_checker
// Port-level checks for the feeder jam detect and reverse block.
// ----------------------------------------------------------------------------
module fjdr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_speed_target_out,
   input logic               rsp_reversing,
   input logic               rsp_jam_detected
);

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // with no result pending the block must take a transfer
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result stage");

   // two buffered ticks at most: a full block drops ready until a take
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !req_ready |=> !req_ready || rsp_ready
         || $past(rsp_ready))
      else $error("input reopened while result stage stalled");

   // stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_speed_target_out)
         && $stable(rsp_reversing) && $stable(rsp_jam_detected))
      else $error("result changed while stalled");

endmodule

bind feeder_jam_detect_reverse_core fjdr_checker u_fjdr_checker (.*);

// ===== verif/feeder_jam_detect_reverse_core_tb.sv =====
// ----------------------------------------------------------------------------
// feeder_jam_detect_reverse_core_tb
// Drives control ticks through the feeder jam detector under several register
// settings and random handshake pressure. A scoreboard predicts the stall
// counters, jam flag and reverse override of every tick and compares each
// result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module feeder_jam_detect_reverse_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import fjdr_pkg::*;

   localparam int STALL_LIMIT   = 4000;
   localparam int NUM_PHASES    = 9;
   localparam int TICKS_PER_PHASE = 64;

   typedef struct {
      logic signed [15:0] speed;
      bit                 rev;
      bit                 jam;
   } tick_result_type;

   class jam_scoreboard;
      cfg_type           cfg;
      logic [7:0]        stall_cnt [4];
      bit                rev_active;
      logic [7:0]        rev_cnt;
      tick_result_type   expected_q [$];
      int                mismatches;
      int                seen;

      function new();
         cfg.position_tolerance = RST_POSITION_TOLERANCE;
         cfg.speed_floor        = RST_SPEED_FLOOR;
         cfg.limit_single       = RST_LIMIT_SINGLE;
         cfg.limit_triple       = RST_LIMIT_TRIPLE;
         cfg.limit_full_auto    = RST_LIMIT_FULL_AUTO;
         cfg.limit_host_ctrl    = RST_LIMIT_HOST_CTRL;
         cfg.reverse_ticks      = RST_REVERSE_TICKS;
         cfg.reverse_speed      = RST_REVERSE_SPEED;
         foreach (stall_cnt[i]) stall_cnt[i] = '0;
         rev_active = 0;
         rev_cnt    = '0;
         mismatches = 0;
         seen       = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [15:0] val);
         case (idx)
            CSR_POSITION_TOLERANCE: cfg.position_tolerance = val;
            CSR_SPEED_FLOOR:        cfg.speed_floor        = val[14:0];
            CSR_LIMIT_SINGLE:       cfg.limit_single       = val[7:0];
            CSR_LIMIT_TRIPLE:       cfg.limit_triple       = val[7:0];
            CSR_LIMIT_FULL_AUTO:    cfg.limit_full_auto    = val[7:0];
            CSR_LIMIT_HOST_CTRL:    cfg.limit_host_ctrl    = val[7:0];
            CSR_REVERSE_TICKS:      cfg.reverse_ticks      = val[7:0];
            CSR_REVERSE_SPEED:      cfg.reverse_speed      = val;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // one accepted tick: update the jam state and queue its result
      function void note_tick(mode_type mode, bit idle, logic signed [31:0] enc,
                              logic signed [31:0] tgt, logic signed [15:0] spd,
                              logic signed [15:0] speed_in);
         longint          err;
         int              spd_mag;
         bit              stall;
         logic [7:0]      cnt;
         logic [7:0]      lim;
         tick_result_type r;
         if (idle) begin
            foreach (stall_cnt[i]) stall_cnt[i] = '0;
         end
         if (mode == MODE_FULL_AUTO) begin
            spd_mag = (spd < 0) ? -int'(spd) : int'(spd);
            stall = spd_mag < int'(cfg.speed_floor);
         end else begin
            // 33-bit exact difference, no wrap
            err = longint'(enc) - longint'(tgt);
            if (err < 0) err = -err;
            stall = err > longint'(cfg.position_tolerance);
         end
         foreach (stall_cnt[i]) begin
            if (i != int'(mode)) stall_cnt[i] = '0;
         end
         cnt = stall ? stall_cnt[mode] + 8'd1 : 8'd0;
         stall_cnt[mode] = cnt;
         case (mode)
            MODE_SINGLE:    lim = cfg.limit_single;
            MODE_TRIPLE:    lim = cfg.limit_triple;
            MODE_FULL_AUTO: lim = cfg.limit_full_auto;
            default:        lim = cfg.limit_host_ctrl;
         endcase
         r.jam = (cnt >= lim);
         r.rev = 0;
         if (r.jam) begin
            rev_active = 1;
            foreach (stall_cnt[i]) stall_cnt[i] = '0;
         end
         // a jam during reversal does not restart the count
         if (rev_active) begin
            rev_cnt = rev_cnt + 8'd1;
            if (rev_cnt >= cfg.reverse_ticks) begin
               rev_active = 0;
               rev_cnt    = '0;
            end else begin
               r.rev = 1;
            end
         end
         r.speed = r.rev ? cfg.reverse_speed : speed_in;
         expected_q.push_back(r);
      endfunction

      function void check_result(logic signed [15:0] speed, bit rev, bit jam);
         tick_result_type r;
         seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: no tick waiting (speed %0d rev %0b jam %0b)",
                        seen, speed, rev, jam);
         end else begin
            r = expected_q.pop_front();
            if (speed !== r.speed || rev !== r.rev || jam !== r.jam) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result %0d: exp speed %0d rev %0b jam %0b,",
                            " got speed %0d rev %0b jam %0b"},
                           seen, r.speed, r.rev, r.jam, speed, rev, jam);
            end
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [1:0]              req_fire_mode;
   logic                    req_firing_idle;
   logic signed [31:0]      req_encoder_position;
   logic signed [31:0]      req_position_target;
   logic signed [15:0]      req_measured_speed;
   logic signed [15:0]      req_speed_target_in;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [15:0]      rsp_speed_target_out;
   logic                    rsp_reversing;
   logic                    rsp_jam_detected;
   logic                    csr_we;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   jam_scoreboard sb;
   int            send_gap_pct;
   int            rsp_stall_pct;
   int            quiet_cycles;

   feeder_jam_detect_reverse_core u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_fire_mode        (req_fire_mode),
      .req_firing_idle      (req_firing_idle),
      .req_encoder_position (req_encoder_position),
      .req_position_target  (req_position_target),
      .req_measured_speed   (req_measured_speed),
      .req_speed_target_in  (req_speed_target_in),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_speed_target_out (rsp_speed_target_out),
      .rsp_reversing        (rsp_reversing),
      .rsp_jam_detected     (rsp_jam_detected),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // valid stays high between back-to-back ticks, drops only for a gap
   task automatic send_tick(mode_type mode, bit idle, logic signed [31:0] enc,
                            logic signed [31:0] tgt, logic signed [15:0] spd,
                            logic signed [15:0] speed_in);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_gap_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_fire_mode        <= mode;
      req_firing_idle      <= idle;
      req_encoder_position <= enc;
      req_position_target  <= tgt;
      req_measured_speed   <= spd;
      req_speed_target_in  <= speed_in;
      do @(posedge clock); while (!req_ready);
      sb.note_tick(mode, idle, enc, tgt, spd, speed_in);
   endtask

   // stop sending and let every pending result drain
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_regs(cfg_type c);
      logic [15:0]   vals [8];
      csr_index_type idx;
      vals[CSR_POSITION_TOLERANCE] = c.position_tolerance;
      vals[CSR_SPEED_FLOOR]        = {1'b0, c.speed_floor};
      vals[CSR_LIMIT_SINGLE]       = {8'd0, c.limit_single};
      vals[CSR_LIMIT_TRIPLE]       = {8'd0, c.limit_triple};
      vals[CSR_LIMIT_FULL_AUTO]    = {8'd0, c.limit_full_auto};
      vals[CSR_LIMIT_HOST_CTRL]    = {8'd0, c.limit_host_ctrl};
      vals[CSR_REVERSE_TICKS]      = {8'd0, c.reverse_ticks};
      vals[CSR_REVERSE_SPEED]      = c.reverse_speed;
      idx = idx.first();
      repeat (idx.num()) begin
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= vals[idx];
         sb.set_reg(idx, vals[idx]);
         @(posedge clock);
         idx = idx.next();
      end
      csr_we <= 1'b0;
   endtask

   // well-formed tick that stalls or not as asked, with random content; some are fully random
   task automatic random_tick(mode_type mode, bit want_stall);
      logic signed [31:0] tgt;
      logic signed [31:0] off;
      logic signed [15:0] spd;
      int                 mag;
      bit                 idle;
      idle = ($urandom_range(0, 99) < 4);
      if ($urandom_range(0, 99) < 8) begin
         send_tick(mode_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   $urandom, $urandom, 16'($urandom), 16'($urandom));
      end else begin
         tgt = $signed($urandom) >>> 2;
         if (want_stall)
            mag = int'(sb.cfg.position_tolerance) + 1 + $urandom_range(0, 3000);
         else
            mag = $urandom_range(0, sb.cfg.position_tolerance);
         off = $urandom_range(0, 1) ? -mag : mag;
         if (mode == MODE_FULL_AUTO) begin
            if (want_stall && sb.cfg.speed_floor != 0)
               mag = $urandom_range(0, sb.cfg.speed_floor - 1);
            else
               mag = $urandom_range(sb.cfg.speed_floor, 32768);
            spd = 16'($urandom_range(0, 1) ? -mag : mag);
         end else begin
            spd = 16'($urandom);
         end
         send_tick(mode, idle, tgt + off, tgt, spd, 16'($urandom));
      end
   endtask

   function automatic cfg_type phase_cfg(int phase);
      cfg_type c;
      c.position_tolerance = 16'($urandom_range(0, 4000));
      c.speed_floor        = 15'($urandom_range(0, 2000));
      c.limit_single       = 8'($urandom_range(1, 12));
      c.limit_triple       = 8'($urandom_range(1, 12));
      c.limit_full_auto    = 8'($urandom_range(1, 12));
      c.limit_host_ctrl    = 8'($urandom_range(1, 12));
      c.reverse_ticks      = 8'($urandom_range(1, 12));
      c.reverse_speed      = 16'($urandom);
      case (phase)
         1: begin
            c.position_tolerance = '0;
            c.speed_floor        = '0;
            c.limit_single       = 8'd255;
            c.limit_triple       = 8'd255;
            c.limit_full_auto    = 8'd255;
            c.limit_host_ctrl    = 8'd255;
            c.reverse_ticks      = 8'd255;
            c.reverse_speed      = -16'sd32768;
         end
         4: begin
            // zero limits jam on every tick, zero reverse ticks never override
            c.position_tolerance = 16'hFFFF;
            c.speed_floor        = 15'h7FFF;
            c.limit_single       = '0;
            c.limit_triple       = '0;
            c.limit_full_auto    = '0;
            c.limit_host_ctrl    = '0;
            c.reverse_ticks      = '0;
            c.reverse_speed      = 16'sd32767;
         end
         7: begin
            c.speed_floor        = 15'h7FFF;
            c.limit_single       = 8'd1;
            c.limit_triple       = 8'd1;
            c.limit_full_auto    = 8'd1;
            c.limit_host_ctrl    = 8'd1;
            c.reverse_ticks      = 8'd1;
         end
         default: ;
      endcase
      return c;
   endfunction

   // receiver: check on transfer, then pick next ready
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result(rsp_speed_target_out, rsp_reversing, rsp_jam_detected);
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      cfg_type  c;
      mode_type mode;
      int       run_len;
      int       count;
      sb = new();
      send_gap_pct         = 7;
      rsp_stall_pct        = 72;
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_fire_mode        <= MODE_SINGLE;
      req_firing_idle      <= 1'b0;
      req_encoder_position <= '0;
      req_position_target  <= '0;
      req_measured_speed   <= '0;
      req_speed_target_in  <= '0;
      csr_we               <= 1'b0;
      csr_index            <= CSR_POSITION_TOLERANCE;
      csr_wdata            <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: tolerance and floor boundaries
      send_tick(MODE_SINGLE, 0, 32'sd2000, 32'sd0, 16'sd0, 16'sd32767);
      send_tick(MODE_SINGLE, 0, 32'sd0, 32'sd2001, 16'sd0, -16'sd32768);
      send_tick(MODE_FULL_AUTO, 0, 32'sd0, 32'sd0, 16'sd499, 16'sd1);
      send_tick(MODE_FULL_AUTO, 0, 32'sd0, 32'sd0, 16'sd500, 16'sd2);
      send_tick(MODE_FULL_AUTO, 0, 32'sd0, 32'sd0, -16'sd32768, 16'sd3);
      drain();

      c = phase_cfg(0);
      c.position_tolerance = 16'd10;
      c.speed_floor        = 15'd100;
      c.limit_single       = 8'd2;
      c.limit_triple       = 8'd3;
      c.limit_full_auto    = 8'd1;
      c.limit_host_ctrl    = 8'd1;
      c.reverse_ticks      = 8'd4;
      c.reverse_speed      = -16'sd1234;
      write_regs(c);
      // largest errors both ways, then a jam that ends in a reversal
      send_tick(MODE_SINGLE, 0, 32'sh7FFFFFFF, 32'sh80000000, 16'sd0, 16'sd10);
      send_tick(MODE_SINGLE, 0, 32'sh80000000, 32'sh7FFFFFFF, 16'sd0, 16'sd11);
      send_tick(MODE_HOST_CTRL, 0, 32'sd0, 32'sd0, 16'sd0, 16'sd12);
      // jam while reversing
      send_tick(MODE_HOST_CTRL, 0, -32'sd11, 32'sd0, 16'sd0, 16'sd13);
      send_tick(MODE_TRIPLE, 1, 32'sd50, 32'sd0, 16'sd0, 16'sd14);
      send_tick(MODE_FULL_AUTO, 0, 32'sd0, 32'sd0, -16'sd32768, 16'sd15);
      send_tick(MODE_FULL_AUTO, 0, 32'sd0, 32'sd0, 16'sd99, 16'sd16);
      // idle clears, then the active counter still counts this tick
      send_tick(MODE_FULL_AUTO, 1, 32'sd0, 32'sd0, 16'sd0, 16'sd17);
      send_tick(MODE_TRIPLE, 0, 32'sd0, 32'sd20, 16'sd0, 16'sd18);
      send_tick(MODE_TRIPLE, 0, 32'sd0, 32'sd20, 16'sd0, 16'sd19);
      send_tick(MODE_TRIPLE, 1, 32'sd0, 32'sd20, 16'sd0, 16'sd20);
      send_tick(MODE_TRIPLE, 0, 32'sd0, 32'sd20, 16'sd0, 16'sd21);
      send_tick(MODE_SINGLE, 0, 32'sd0, 32'sd20, 16'sd0, 16'sd22);
      send_tick(MODE_TRIPLE, 0, 32'sd0, 32'sd20, 16'sd32767, 16'sd23);
      drain();

      // leave a long reversal running so the next phase lowers its length
      c.reverse_ticks = 8'd40;
      write_regs(c);
      send_tick(MODE_HOST_CTRL, 0, 32'sd100, 32'sd0, 16'sd0, 16'sd24);
      send_tick(MODE_SINGLE, 0, 32'sd0, 32'sd0, 16'sd0, 16'sd25);
      send_tick(MODE_SINGLE, 0, 32'sd0, 32'sd0, 16'sd0, 16'sd26);
      drain();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase == 3) begin
            send_gap_pct  = 72;
            rsp_stall_pct = 7;
         end else if (phase == 6) begin
            send_gap_pct  = 0;
            rsp_stall_pct = 0;
         end
         write_regs(phase_cfg(phase));
         count = 0;
         while (count < TICKS_PER_PHASE) begin
            mode    = mode_type'($urandom_range(0, 3));
            run_len = $urandom_range(1, 24);
            repeat (run_len) begin
               random_tick(mode, $urandom_range(0, 99) < 85);
               count++;
            end
         end
         drain();
      end

      repeat (4) @(posedge clock);
      sb.mismatches += sb.pending();
      if (sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
